// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and the digit-to-ASCII mapping for the integer to ASCII converter.
// Used by itoa_div, integer_to_ascii_radix_core and the testbench; depends on nothing else.
package itoa_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;

  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 8;
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W    = $clog2(MAX_DIGITS);
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);

  localparam logic CMD_SIGNED_DEC = 1'b0;
  localparam logic CMD_RADIX      = 1'b1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  // 'a' minus ten, so that digit ten maps to 'a'
  localparam logic [CHAR_W-1:0] CHAR_HEX_BASE = 8'd87;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;   // take a new dividend and radix, start a pass
    logic next;   // divide the held quotient again
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;     // one-cycle pulse at the end of a pass
    logic quot_nz;  // quotient of the finished pass is nonzero
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d_ext;
    end else begin
      return CHAR_HEX_BASE + d_ext;
    end
  endfunction

endpackage

// ===== rtl/itoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/itoa_div.sv =====
// Bit-serial restoring divider: divides the held value by a small radix, one quotient bit per cycle.
// Depends on itoa_pkg for widths and the control/status structs.
module itoa_div
  import itoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  div_ctrl_t              ctrl,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_W-1:0]     radix,
  output div_stat_t              stat,
  output logic [DIGIT_W-1:0]     rem
);

  logic [VALUE_WIDTH-1:0] work_r, work_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     radix_r, radix_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic                   qnz_r, qnz_nxt;

  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] trial_sub;
  logic               qbit;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial     = {rem_r, work_r[VALUE_WIDTH-1]};
  assign qbit      = (trial >= radix_r);
  assign trial_sub = trial - radix_r;

  always_comb begin
    work_nxt    = work_r;
    rem_nxt     = rem_r;
    radix_nxt   = radix_r;
    bit_cnt_nxt = bit_cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    qnz_nxt     = qnz_r;
    if (ctrl.load) begin
      work_nxt    = value;
      radix_nxt   = radix;
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      busy_nxt    = 1'b1;
      qnz_nxt     = 1'b0;
    end else if (ctrl.next) begin
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      busy_nxt    = 1'b1;
      qnz_nxt     = 1'b0;
    end else if (busy_r) begin
      // Quotient bits fill in from the bottom as the dividend leaves the top.
      work_nxt    = {work_r[VALUE_WIDTH-2:0], qbit};
      rem_nxt     = qbit ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      qnz_nxt     = qnz_r | qbit;
      bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
      if (bit_cnt_r == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      qnz_r     <= 1'b0;
    end else begin
      bit_cnt_r <= bit_cnt_nxt;
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
      qnz_r     <= qnz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  assign stat.busy    = busy_r;
  assign stat.done    = done_r;
  assign stat.quot_nz = qnz_r;
  assign rem          = rem_r;

endmodule

// ===== rtl/integer_to_ascii_radix_core.sv =====
// Integer to ASCII converter top level: sequencer, digit store and output register.
// Depends on itoa_pkg, itoa_div and itoa_ram.
//
// Input channel (in_valid/in_stall): one transaction carries a command, a
// 64-bit value and a radix. Command 0 prints the value as signed decimal;
// command 1 prints it unsigned in the given radix (clamped to 2..16).
// Output channel (out_valid/out_stall): one ASCII character per transaction,
// most significant first, a leading '-' for negatives, out_last on the final
// character. Zero prints as a single '0'.
// One number is handled at a time; in_stall stays high from acceptance until
// the final character has been loaded into the output register, so the next
// number is accepted while that character still waits to be taken.
// Each digit costs one pass of the bit-serial divider. Emission takes a RAM
// read, then an output load, per digit, with a sign state ahead of them for
// negatives.
// A stalled receiver holds the output register and pauses emission.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops
// out_valid; the digit RAM needs no clearing since every digit is written
// before it is read.
module integer_to_ascii_radix_core
  import itoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [63:0]        in_value,
  input  logic [RADIX_W-1:0] in_radix,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic in_accept;
  logic out_free;
  logic more_digits;

  logic [VALUE_WIDTH-1:0] val_in;
  logic                   val_neg;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [RADIX_W-1:0]     radix_eff;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [DIGIT_W-1:0] div_rem;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re;
  logic [DIGIT_W-1:0] ram_rdata;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign val_in    = in_value[VALUE_WIDTH-1:0];
  assign val_neg   = (in_command == CMD_SIGNED_DEC) && val_in[VALUE_WIDTH-1];
  // The most negative value negates to itself, which read unsigned is the right magnitude.
  assign magnitude = val_neg ? (~val_in + VALUE_WIDTH'(1)) : val_in;

  always_comb begin
    if (in_command == CMD_SIGNED_DEC) begin
      radix_eff = RADIX_DEC;
    end else if (in_radix inside {[RADIX_MIN:RADIX_MAX]}) begin
      radix_eff = in_radix;
    end else if (in_radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else begin
      radix_eff = RADIX_MAX;
    end
  end

  // Keep dividing while the quotient is nonzero and the digit store has room.
  assign more_digits = div_stat.quot_nz &&
                       ((cnt_r + CNT_W'(1)) < CNT_W'(MAX_DIGITS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done && !more_digits) begin
          state_nxt = neg_r ? ST_SIGN : ST_RD;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = (idx_r == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath controls
  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    div_ctrl      = '0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          div_ctrl.load = 1'b1;
          neg_nxt       = val_neg;
          cnt_nxt       = '0;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (more_digits) begin
            div_ctrl.next = 1'b1;
          end else begin
            idx_nxt = cnt_r[ADDR_W-1:0];
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(ram_rdata);
          out_last_nxt  = (idx_r == '0);
          if (idx_r != '0) begin
            idx_nxt = idx_r - ADDR_W'(1);
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  itoa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .value (magnitude),
    .radix (radix_eff),
    .stat  (div_stat),
    .rem   (div_rem)
  );

  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // A division pass only finishes while the sequencer is waiting for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // A new number is never taken while the divider is still running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> !div_stat.busy)
    else $error("input accepted while divider busy");

  // The digit count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  // The output state is entered only from the RAM read state, the cycle after the read was issued.
  a_out_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && ($past(state_r) != ST_OUT) |-> ($past(state_r) == ST_RD))
    else $error("output state entered without a RAM read");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for integer_to_ascii_radix_core: signed decimal and radix conversion.
// A clocked driver and monitor run against a built-in character predictor; needs itoa_pkg.
module testbench;
  import itoa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               command;
    logic [63:0]        value;
    logic [RADIX_W-1:0] radix;
  } number_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } ascii_char_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = 1'b0;
  logic [63:0]        in_value = '0;
  logic [RADIX_W-1:0] in_radix = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last;

  number_t     number_queue[$];
  ascii_char_t expected_chars[$];
  number_t     number_on_bus;
  int          error_count = 0;

  int          burst_left = 1;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase_left = 0;
  int          stall_tick = 0;

  integer_to_ascii_radix_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_value     (in_value),
    .in_radix     (in_radix),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Expand one number into the characters the block must print, most significant first.
  function automatic void predict_chars(input number_t n);
    logic [63:0]        mask;
    logic [63:0]        sign_bit;
    logic [63:0]        v;
    logic [63:0]        mag;
    logic [RADIX_W-1:0] base;
    logic               neg;
    logic [3:0]         digits[MAX_DIGITS];
    int                 count;
    ascii_char_t        c;
    mask     = ~64'd0 >> (64 - VALUE_WIDTH);
    sign_bit = 64'd1 << (VALUE_WIDTH - 1);
    v        = n.value & mask;
    neg      = 1'b0;
    base     = n.radix;
    if (n.command == CMD_SIGNED_DEC) begin
      base = RADIX_DEC;
      if ((v & sign_bit) != 64'd0) begin
        neg = 1'b1;
        // most negative value wraps to its own magnitude, 2^(width-1)
        mag = (64'd0 - v) & mask;
      end else begin
        mag = v;
      end
    end else begin
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
      mag = v;
    end
    count = 0;
    if (mag == 64'd0) begin
      digits[0] = 4'd0;
      count = 1;
    end else begin
      while (mag != 64'd0 && count < MAX_DIGITS) begin
        digits[count] = 4'(mag % 64'(base));
        mag = mag / 64'(base);
        count++;
      end
    end
    if (neg) begin
      c.character = CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = count - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) c.character = CHAR_ZERO + CHAR_W'(digits[i]);
      else c.character = 8'd97 + CHAR_W'(digits[i] - 4'd10);
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic add_number(input logic cmd, input logic [63:0] value,
                            input logic [RADIX_W-1:0] radix);
    number_t n;
    n.command = cmd;
    n.value = value;
    n.radix = radix;
    number_queue.push_back(n);
  endtask

  // Driver: bursts of transactions separated by random gaps.
  always @(posedge clk) begin : drive_numbers
    logic    accepted;
    number_t n;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && !in_stall;
      if (accepted) predict_chars(number_on_bus);
      if (!in_valid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (number_queue.size() != 0) begin
          n = number_queue.pop_front();
          number_on_bus = n;
          in_valid   <= 1'b1;
          in_command <= n.command;
          in_value   <= n.value;
          in_radix   <= n.radix;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch among stall patterns, holding each for a random phase length.
  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_phase_left = $urandom_range(20, 300);
      end else begin
        stall_phase_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor: compare every accepted character against the oldest prediction.
  always @(posedge clk) begin : check_chars
    ascii_char_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected character %h last %b", out_character, out_last);
      end else begin
        exp_c = expected_chars.pop_front();
        if (out_character !== exp_c.character || out_last !== exp_c.last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     exp_c.character, exp_c.last, out_character, out_last);
        end
      end
    end
  end

  initial begin : stimulus
    logic [63:0]        v;
    logic               cmd;
    logic [RADIX_W-1:0] radix;
    int                 pick;
    int                 len;

    // directed: sign edges, zero, clamped radix, longest strings, every hex letter
    add_number(CMD_SIGNED_DEC, 64'd0, 5'd0);
    add_number(CMD_SIGNED_DEC, 64'd1, 5'd0);
    add_number(CMD_SIGNED_DEC, ~64'd0, 5'd0);
    add_number(CMD_SIGNED_DEC, 64'h7fff_ffff_ffff_ffff, 5'd0);
    add_number(CMD_SIGNED_DEC, 64'h8000_0000_0000_0000, 5'd0);
    add_number(CMD_SIGNED_DEC, 64'd12345, 5'd16);
    add_number(CMD_SIGNED_DEC, 64'hffff_ffff_ffff_fff6, 5'd31);
    add_number(CMD_SIGNED_DEC, 64'd9, 5'd2);
    add_number(CMD_SIGNED_DEC, 64'd10, 5'd10);
    add_number(CMD_SIGNED_DEC, 64'hffff_ffff_ffff_fffb, 5'd31);
    add_number(CMD_RADIX, ~64'd0, 5'd2);
    add_number(CMD_RADIX, ~64'd0, 5'd16);
    add_number(CMD_RADIX, ~64'd0, 5'd10);
    add_number(CMD_RADIX, 64'd5, 5'd0);
    add_number(CMD_RADIX, 64'd6, 5'd1);
    add_number(CMD_RADIX, 64'hdead_beef, 5'd31);
    add_number(CMD_RADIX, 64'd255, 5'd17);
    add_number(CMD_RADIX, 64'd8, 5'd8);
    add_number(CMD_RADIX, 64'd0, 5'd3);
    add_number(CMD_RADIX, 64'hfedc_ba98_7654_3210, 5'd16);
    add_number(CMD_RADIX, 64'h8000_0000_0000_0000, 5'd7);
    add_number(CMD_RADIX, 64'd14, 5'd15);
    add_number(CMD_RADIX, 64'd0, 5'd31);

    repeat (480) begin
      cmd = 1'($urandom_range(0, 1));
      radix = ($urandom_range(0, 9) < 7) ? RADIX_W'($urandom_range(2, 16))
                                         : RADIX_W'($urandom_range(0, 31));
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        v = {$urandom, $urandom};
      end else if (pick == 3) begin
        case ($urandom_range(0, 4))
          0: v = 64'd0;
          1: v = ~64'd0;
          2: v = 64'h8000_0000_0000_0000;
          3: v = 64'h7fff_ffff_ffff_ffff;
          default: v = 64'($urandom_range(0, 20));
        endcase
      end else begin
        // short magnitudes need fewer bit-serial divider passes
        len = $urandom_range(1, 40);
        v = {$urandom, $urandom} & (~64'd0 >> (64 - len));
        if (cmd == CMD_SIGNED_DEC && $urandom_range(0, 1) == 1) v = 64'd0 - v;
      end
      add_number(cmd, v, radix);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (number_queue.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for the worst case, about 500 numbers of 64 binary digits with long stalls.
  initial begin : watchdog
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itoa_pkg.sv
rtl/itoa_ram.sv
rtl/itoa_div.sv
rtl/integer_to_ascii_radix_core.sv
dv/testbench.sv
